>>> hw/rtl/twdfs_pkg.sv
// Shared types and constants for the two-wire display frame sender.
`timescale 1ns / 1ps

package twdfs_pkg;

	// Frame geometry
	localparam int MAX_DATA_BYTES = 4;
	localparam int STORE_DEPTH    = MAX_DATA_BYTES + 1;
	localparam int BYTE_W         = 8;
	localparam int BIT_IDX_W      = $clog2(BYTE_W);
	localparam int BYTE_IDX_W     = $clog2(STORE_DEPTH);
	localparam int COUNT_W        = 3;

	// Bit period register
	localparam int          PERIOD_W     = 16;
	localparam logic [15:0] PERIOD_RESET = 16'd500;

	// Stream widths
	localparam int IN_DATA_W  = 48;
	localparam int OUT_DATA_W = 8;

	// Operation codes carried on s_tuser
	localparam logic OP_PLAIN = 1'b0;
	localparam logic OP_START = 1'b1;

	// One input beat, unpacked
	typedef struct packed {
		logic                      operation;
		logic [BYTE_W-1:0]         cmd_byte;
		logic [MAX_DATA_BYTES*BYTE_W-1:0] data_bytes;
		logic [COUNT_W-1:0]        data_count;
		logic                      dio_in;
	} item_t;

	// One result beat; clk_out is the lowest bit
	typedef struct packed {
		logic status;
		logic done_res;
		logic busy_res;
		logic dio_out;
		logic clk_out;
	} result_t;

endpackage

>>> hw/rtl/twdfs_engine.sv
// Pin-level frame sequencer: advances one system cycle per accepted beat.
`timescale 1ns / 1ps

module twdfs_engine
	import twdfs_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                adv,
	input  item_t               item,
	input  logic [PERIOD_W-1:0] period,
	output result_t             res
);

	typedef enum logic [2:0] {
		PH_IDLE,
		PH_START,
		PH_BIT_LOW,
		PH_BIT_HIGH,
		PH_ACK_LOW,
		PH_ACK_HIGH,
		PH_STOP_LOW,
		PH_STOP_HIGH
	} phase_t;

	phase_t                phase_q, phase_d;
	logic [BIT_IDX_W-1:0]  bit_idx_q, bit_idx_d;
	logic [BYTE_IDX_W-1:0] byte_idx_q, byte_idx_d;
	logic [COUNT_W-1:0]    nbytes_q, nbytes_d;
	logic [PERIOD_W-1:0]   cnt_q, cnt_d;
	logic                  clk_lvl_q, clk_lvl_d;
	logic                  dio_lvl_q, dio_lvl_d;
	logic                  nack_q, nack_d;
	logic [BYTE_W-1:0]     frame_q [STORE_DEPTH];

	logic                  store_we;
	logic                  done;
	logic                  stat;
	logic [PERIOD_W-1:0]   load;
	logic [COUNT_W-1:0]    count_sat;
	logic [BYTE_W-1:0]     cur_byte;

	// Zero period behaves as one
	assign load = (period == '0) ? PERIOD_W'(1) : period;

	assign count_sat = (item.data_count > COUNT_W'(MAX_DATA_BYTES))
		? COUNT_W'(MAX_DATA_BYTES) : item.data_count;

	assign cur_byte = frame_q[byte_idx_q];

	// Next-state logic for one cycle
	always_comb begin
		phase_d    = phase_q;
		bit_idx_d  = bit_idx_q;
		byte_idx_d = byte_idx_q;
		nbytes_d   = nbytes_q;
		cnt_d      = cnt_q;
		clk_lvl_d  = clk_lvl_q;
		dio_lvl_d  = dio_lvl_q;
		nack_d     = nack_q;
		store_we   = 1'b0;
		done       = 1'b0;
		stat       = 1'b0;
		if (phase_q == PH_IDLE) begin
			if (item.operation == OP_START) begin
				store_we   = 1'b1;
				nbytes_d   = count_sat + COUNT_W'(1);
				byte_idx_d = '0;
				bit_idx_d  = '0;
				nack_d     = 1'b0;
				dio_lvl_d  = 1'b0;
				phase_d    = PH_START;
				cnt_d      = load;
			end
		end else if (cnt_q > PERIOD_W'(1)) begin
			cnt_d = cnt_q - PERIOD_W'(1);
		end else begin
			unique case (phase_q)
				PH_START: begin
					clk_lvl_d = 1'b0;
					bit_idx_d = '0;
					phase_d   = PH_BIT_LOW;
					cnt_d     = load;
				end
				PH_BIT_LOW: begin
					dio_lvl_d = cur_byte[bit_idx_q];
					clk_lvl_d = 1'b1;
					phase_d   = PH_BIT_HIGH;
					cnt_d     = load;
				end
				PH_BIT_HIGH: begin
					clk_lvl_d = 1'b0;
					cnt_d     = load;
					if (bit_idx_q != BIT_IDX_W'(BYTE_W - 1)) begin
						bit_idx_d = bit_idx_q + BIT_IDX_W'(1);
						phase_d   = PH_BIT_LOW;
					end else begin
						dio_lvl_d = 1'b1;
						phase_d   = PH_ACK_LOW;
					end
				end
				PH_ACK_LOW: begin
					nack_d    = item.dio_in;
					clk_lvl_d = 1'b1;
					phase_d   = PH_ACK_HIGH;
					cnt_d     = load;
				end
				PH_ACK_HIGH: begin
					if (nack_q) begin
						// no acknowledge: release both lines and abort
						clk_lvl_d = 1'b1;
						dio_lvl_d = 1'b1;
						phase_d   = PH_IDLE;
						cnt_d     = '0;
						done      = 1'b1;
						stat      = 1'b1;
					end else if (COUNT_W'(byte_idx_q) + COUNT_W'(1) < nbytes_q) begin
						byte_idx_d = byte_idx_q + BYTE_IDX_W'(1);
						bit_idx_d  = '0;
						clk_lvl_d  = 1'b0;
						phase_d    = PH_BIT_LOW;
						cnt_d      = load;
					end else begin
						dio_lvl_d = 1'b0;
						clk_lvl_d = 1'b0;
						phase_d   = PH_STOP_LOW;
						cnt_d     = load;
					end
				end
				PH_STOP_LOW: begin
					clk_lvl_d = 1'b1;
					phase_d   = PH_STOP_HIGH;
					cnt_d     = load;
				end
				PH_STOP_HIGH: begin
					dio_lvl_d = 1'b1;
					phase_d   = PH_IDLE;
					cnt_d     = '0;
					done      = 1'b1;
				end
				default: begin
					phase_d = PH_IDLE;
				end
			endcase
		end
	end

	// Result of this beat
	always_comb begin
		res.clk_out  = clk_lvl_d;
		res.dio_out  = dio_lvl_d;
		res.busy_res = (phase_d != PH_IDLE);
		res.done_res = done;
		res.status   = stat;
	end

	// Control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= PH_IDLE;
			bit_idx_q  <= '0;
			byte_idx_q <= '0;
			nbytes_q   <= '0;
			cnt_q      <= '0;
			clk_lvl_q  <= 1'b1;
			dio_lvl_q  <= 1'b1;
			nack_q     <= 1'b0;
		end else if (adv) begin
			phase_q    <= phase_d;
			bit_idx_q  <= bit_idx_d;
			byte_idx_q <= byte_idx_d;
			nbytes_q   <= nbytes_d;
			cnt_q      <= cnt_d;
			clk_lvl_q  <= clk_lvl_d;
			dio_lvl_q  <= dio_lvl_d;
			nack_q     <= nack_d;
		end
	end

	// Frame bytes, loaded in full at frame start
	always_ff @(posedge clk) begin
		if (adv && store_we) begin
			frame_q[0] <= item.cmd_byte;
			for (int i = 0; i < MAX_DATA_BYTES; i++) begin
				frame_q[i + 1] <= item.data_bytes[i*BYTE_W +: BYTE_W];
			end
		end
	end

endmodule

>>> hw/rtl/two_wire_display_frame_sender.sv
// Top level: stream ports, bit period register and result register.
// Result: each result beat is registered and offered in the cycle after its input beat is accepted.
// Throughput: one beat per cycle while the result register is empty or draining; each beat is one
//   system cycle of the line sequencer, set by the combinational next-state logic in twdfs_engine.
// Reset: arst_n clears the sequencer to idle with both lines released high,
//   empties the result register and loads the bit period with 500.
`timescale 1ns / 1ps

module two_wire_display_frame_sender
	import twdfs_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [PERIOD_W-1:0]   cfg_data,    // bit_period_ticks
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [IN_DATA_W-1:0]  s_tdata,     // cmd_byte, data_bytes, data_count, dio_in
	input  logic                  s_tuser,     // operation
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [OUT_DATA_W-1:0] m_tdata      // clk_out, dio_out, busy_res, done_res, status
);

	logic [PERIOD_W-1:0] period_q;
	logic                m_tvalid_q;
	result_t             res_q;
	result_t             res;
	item_t               item;
	logic                in_beat;

	assign cfg_ready = 1'b1;
	assign s_tready  = !m_tvalid_q || m_tready;
	assign in_beat   = s_tvalid && s_tready;

	// Unpack the input beat
	always_comb begin
		item.operation  = s_tuser;
		item.cmd_byte   = s_tdata[7:0];
		item.data_bytes = s_tdata[39:8];
		item.data_count = s_tdata[42:40];
		item.dio_in     = s_tdata[43];
	end

	// Bit period register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			period_q <= PERIOD_RESET;
		end else if (cfg_valid && cfg_ready) begin
			period_q <= cfg_data;
		end
	end

	twdfs_engine u_engine (
		.clk    (clk),
		.arst_n (arst_n),
		.adv    (in_beat),
		.item   (item),
		.period (period_q),
		.res    (res)
	);

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (in_beat) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_beat) begin
			res_q <= res;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {(OUT_DATA_W - $bits(result_t))'(0), res_q};

endmodule

>>> hw/rtl/twdfs_checker.sv
// Port-level checks for the two-wire display frame sender, bound to the top.
`timescale 1ns / 1ps

module twdfs_checker
	import twdfs_pkg::*;
(
	input logic                  clk,
	input logic                  arst_n,
	input logic                  s_tready,
	input logic                  m_tvalid,
	input logic                  m_tready,
	input logic [OUT_DATA_W-1:0] m_tdata
);

	// Empty or draining result register never blocks the input
	a_ready_when_free: assert property (@(posedge clk) disable iff (!arst_n)
		(!m_tvalid || m_tready) |-> s_tready)
		else $error("input stalled with free result register");

	// A finished frame is no longer busy
	a_done_not_busy: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[3] |-> !m_tdata[2])
		else $error("done beat still busy");

	// Error status only with done
	a_status_with_done: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[4] |-> m_tdata[3])
		else $error("status without done");

	// Both lines released at frame end
	a_lines_released: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[3] |-> m_tdata[0] && m_tdata[1])
		else $error("lines not released at frame end");

	// Unused pad bits stay low
	a_pad_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[OUT_DATA_W-1:$bits(result_t)] == '0)
		else $error("nonzero pad bits");

endmodule

bind two_wire_display_frame_sender twdfs_checker u_twdfs_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);

>>> sim/twdfs_line_checker.sv
// Line-level predictor and result checker for the two-wire display frame sender.
`timescale 1ns / 1ps

module twdfs_line_checker
	import twdfs_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_valid,
	input  logic                  cfg_ready,
	input  logic [PERIOD_W-1:0]   cfg_data,
	input  logic                  s_tvalid,
	input  logic                  s_tready,
	input  logic [IN_DATA_W-1:0]  s_tdata,
	input  logic                  s_tuser,
	input  logic                  m_tvalid,
	input  logic                  m_tready,
	input  logic [OUT_DATA_W-1:0] m_tdata,
	output int                    fail_count,
	output int                    pending,
	output logic                  engine_idle
);

	typedef enum logic [3:0] {
		SEQ_IDLE,
		SEQ_START,
		SEQ_BIT_LOW,
		SEQ_BIT_HIGH,
		SEQ_ACK_LOW,
		SEQ_ACK_HIGH,
		SEQ_STOP_LOW,
		SEQ_STOP_HIGH
	} seq_phase_t;

	// Predicted sequencer state
	seq_phase_t            seq_phase;
	logic [BIT_IDX_W-1:0]  bit_pos;
	logic [BYTE_IDX_W-1:0] byte_pos;
	logic [COUNT_W-1:0]    byte_total;
	logic [BYTE_W-1:0]     frame_bytes [0:STORE_DEPTH-1];
	logic [PERIOD_W-1:0]   ticks_left;
	logic [PERIOD_W-1:0]   period_reg;
	logic                  clk_lvl;
	logic                  dio_lvl;
	logic                  nack_flag;

	// Predicted pin levels, oldest first
	logic [OUT_DATA_W-1:0] pin_levels_q [$];

	string field_name [0:OUT_DATA_W-1] = '{"clk_out", "dio_out", "busy_res", "done_res",
		"status", "pad5", "pad6", "pad7"};

	initial begin
		fail_count  = 0;
		pending     = 0;
		engine_idle = 1'b1;
	end

	// Move to a timed phase and reload the period count (zero counts as one)
	function automatic void enter_phase(seq_phase_t nxt);
		seq_phase  = nxt;
		ticks_left = (period_reg == '0) ? PERIOD_W'(1) : period_reg;
	endfunction

	// One system cycle of the sequencer; returns the pin levels after it
	function automatic result_t step_lines(item_t beat);
		result_t          r;
		logic [BYTE_W-1:0] cur;
		int               cnt;
		r = '0;
		if (seq_phase == SEQ_IDLE) begin
			if (beat.operation == OP_START) begin
				frame_bytes[0] = beat.cmd_byte;
				for (int i = 0; i < MAX_DATA_BYTES; i++)
					frame_bytes[i+1] = beat.data_bytes[BYTE_W*i +: BYTE_W];
				cnt = int'(beat.data_count);
				if (cnt > MAX_DATA_BYTES)
					cnt = MAX_DATA_BYTES;
				byte_total = COUNT_W'(cnt + 1);
				byte_pos   = '0;
				bit_pos    = '0;
				nack_flag  = 1'b0;
				dio_lvl    = 1'b0;
				enter_phase(SEQ_START);
			end
		end else if (ticks_left > PERIOD_W'(1)) begin
			ticks_left = ticks_left - PERIOD_W'(1);
		end else begin
			case (seq_phase)
				SEQ_START: begin
					clk_lvl = 1'b0;
					bit_pos = '0;
					enter_phase(SEQ_BIT_LOW);
				end
				SEQ_BIT_LOW: begin
					cur     = frame_bytes[byte_pos];
					dio_lvl = cur[bit_pos];
					clk_lvl = 1'b1;
					enter_phase(SEQ_BIT_HIGH);
				end
				SEQ_BIT_HIGH: begin
					clk_lvl = 1'b0;
					if (bit_pos != 3'd7) begin
						bit_pos = bit_pos + BIT_IDX_W'(1);
						enter_phase(SEQ_BIT_LOW);
					end else begin
						dio_lvl = 1'b1;
						enter_phase(SEQ_ACK_LOW);
					end
				end
				SEQ_ACK_LOW: begin
					nack_flag = beat.dio_in;
					clk_lvl   = 1'b1;
					enter_phase(SEQ_ACK_HIGH);
				end
				SEQ_ACK_HIGH: begin
					if (nack_flag) begin
						// abort: release both lines
						clk_lvl    = 1'b1;
						dio_lvl    = 1'b1;
						seq_phase  = SEQ_IDLE;
						ticks_left = '0;
						r.done_res = 1'b1;
						r.status   = 1'b1;
					end else if (int'(byte_pos) + 1 < int'(byte_total)) begin
						byte_pos = byte_pos + BYTE_IDX_W'(1);
						bit_pos  = '0;
						clk_lvl  = 1'b0;
						enter_phase(SEQ_BIT_LOW);
					end else begin
						dio_lvl = 1'b0;
						clk_lvl = 1'b0;
						enter_phase(SEQ_STOP_LOW);
					end
				end
				SEQ_STOP_LOW: begin
					clk_lvl = 1'b1;
					enter_phase(SEQ_STOP_HIGH);
				end
				default: begin
					dio_lvl    = 1'b1;
					seq_phase  = SEQ_IDLE;
					ticks_left = '0;
					r.done_res = 1'b1;
				end
			endcase
		end
		r.clk_out  = clk_lvl;
		r.dio_out  = dio_lvl;
		r.busy_res = (seq_phase != SEQ_IDLE);
		return r;
	endfunction

	// Result side first (a result never belongs to the beat of the same edge)
	always @(posedge clk or negedge arst_n) begin
		item_t                 beat;
		logic [OUT_DATA_W-1:0] want;
		if (!arst_n) begin
			seq_phase  = SEQ_IDLE;
			bit_pos    = '0;
			byte_pos   = '0;
			byte_total = '0;
			ticks_left = '0;
			period_reg = PERIOD_RESET;
			clk_lvl    = 1'b1;
			dio_lvl    = 1'b1;
			nack_flag  = 1'b0;
			pin_levels_q.delete();
		end else begin
			if (m_tvalid && m_tready) begin
				if (pin_levels_q.size() == 0) begin
					fail_count++;
					$display("%0t: result beat 0x%02h with no prediction waiting",
						$time, m_tdata);
				end else begin
					want = pin_levels_q.pop_front();
					for (int b = 0; b < OUT_DATA_W; b++) begin
						if (m_tdata[b] !== want[b]) begin
							fail_count++;
							$display("%0t: %s expected %0d got %0d", $time,
								field_name[b], want[b], m_tdata[b]);
						end
					end
				end
			end
			if (s_tvalid && s_tready) begin
				beat.operation  = s_tuser;
				beat.cmd_byte   = s_tdata[7:0];
				beat.data_bytes = s_tdata[39:8];
				beat.data_count = s_tdata[42:40];
				beat.dio_in     = s_tdata[43];
				pin_levels_q.push_back(OUT_DATA_W'(step_lines(beat)));
			end
			// a period write applies from the next beat on
			if (cfg_valid && cfg_ready)
				period_reg = cfg_data;
		end
		pending     = pin_levels_q.size();
		engine_idle = (seq_phase == SEQ_IDLE);
	end

endmodule

>>> sim/tb_two_wire_display_frame_sender.sv
// Testbench top: clock, reset, frame stimulus, bit period changes and verdict.
`timescale 1ns / 1ps

module tb_two_wire_display_frame_sender;
	import twdfs_pkg::*;

	localparam int CYCLE_LIMIT = 1_000_000;
	localparam int GAP_PCT     = 7;

	typedef enum int {ACK_ALL, NACK_FIRST, NACK_SOME} ack_plan_t;

	logic                  clk = 1'b0;
	logic                  arst_n;
	logic                  cfg_valid;
	logic                  cfg_ready;
	logic [PERIOD_W-1:0]   cfg_data;
	logic                  s_tvalid;
	logic                  s_tready;
	logic [IN_DATA_W-1:0]  s_tdata;   // cmd_byte, data_bytes, data_count, dio_in
	logic                  s_tuser;   // operation
	logic                  m_tvalid;
	logic                  m_tready = 1'b0;
	logic [OUT_DATA_W-1:0] m_tdata;   // clk_out, dio_out, busy_res, done_res, status

	int   fail_count;
	int   pending;
	logic engine_idle;
	int   cycle_count = 0;
	int   beats_sent  = 0;
	logic no_gaps     = 1'b0;

	two_wire_display_frame_sender dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata)
	);

	twdfs_line_checker chk (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_data    (cfg_data),
		.s_tvalid    (s_tvalid),
		.s_tready    (s_tready),
		.s_tdata     (s_tdata),
		.s_tuser     (s_tuser),
		.m_tvalid    (m_tvalid),
		.m_tready    (m_tready),
		.m_tdata     (m_tdata),
		.fail_count  (fail_count),
		.pending     (pending),
		.engine_idle (engine_idle)
	);

	always #10 clk = ~clk;

	// Receiver stalls
	always @(negedge clk) begin
		m_tready <= no_gaps || ($urandom_range(0, 99) >= GAP_PCT);
	end

	// Run guard
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("two_wire_display_frame_sender verification failed");
			$finish;
		end
	end

	// Present one beat and hold it until taken; returns on a falling edge
	task automatic send_beat(input logic op, input logic [7:0] cmd, input logic [31:0] data,
		input logic [2:0] count, input logic dio);
		while (!no_gaps && $urandom_range(0, 99) < GAP_PCT) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= op;
		s_tdata  <= {4'b0, dio, count, data, cmd};
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		beats_sent++;
		@(negedge clk);
	endtask

	function automatic logic ack_level(ack_plan_t plan);
		case (plan)
			ACK_ALL:    return 1'b0;
			NACK_FIRST: return 1'b1;
			default:    return ($urandom_range(0, 3) == 0);
		endcase
	endfunction

	// Start a frame from idle and keep cycling until the sequencer is idle again
	task automatic run_frame(input logic [7:0] cmd, input logic [31:0] data,
		input logic [2:0] count, input ack_plan_t plan);
		send_beat(OP_START, cmd, data, count, ack_level(plan));
		while (!engine_idle)
			send_beat(($urandom_range(0, 3) == 0) ? OP_START : OP_PLAIN, 8'($urandom),
				32'($urandom), 3'($urandom_range(0, 7)), ack_level(plan));
	endtask

	task automatic plain_beats(input int n);
		repeat (n)
			send_beat(OP_PLAIN, 8'($urandom), 32'($urandom), 3'($urandom_range(0, 7)),
				1'($urandom_range(0, 1)));
	endtask

	// Period change only with the sequencer idle and all results drained
	task automatic set_period(input logic [PERIOD_W-1:0] ticks);
		s_tvalid <= 1'b0;
		while (pending != 0 || !engine_idle)
			@(negedge clk);
		repeat (2) @(negedge clk);
		cfg_valid <= 1'b1;
		cfg_data  <= ticks;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	initial begin
		int               base;
		logic [PERIOD_W-1:0] ticks;
		ack_plan_t        plan;
		int               pick;
		arst_n    = 1'b0;
		cfg_valid = 1'b0;
		cfg_data  = '0;
		s_tvalid  = 1'b0;
		s_tuser   = OP_PLAIN;
		s_tdata   = '0;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Reset period: idle levels only, a frame there would dwarf the run
		plain_beats(3);

		// Shortest period: field extremes, every count, nacks, back-to-back frames
		set_period(16'd1);
		run_frame(8'h00, 32'h0000_0000, 3'd0, ACK_ALL);
		run_frame(8'hFF, 32'hFFFF_FFFF, 3'd4, ACK_ALL);
		run_frame(8'h40, 32'h1234_5678, 3'd1, ACK_ALL);
		run_frame(8'hC0, 32'h89AB_CDEF, 3'd2, ACK_ALL);
		run_frame(8'h8B, 32'h5A5A_A5A5, 3'd3, ACK_ALL);
		plain_beats(2);
		// counts above the maximum saturate
		run_frame(8'h44, 32'hDEAD_BEEF, 3'd5, ACK_ALL);
		run_frame(8'h55, 32'h0F0F_F0F0, 3'd6, ACK_ALL);
		run_frame(8'hAA, 32'h8000_0001, 3'd7, ACK_ALL);
		// nack on the command byte, then nacks somewhere later
		run_frame(8'h48, 32'h0102_0304, 3'd4, NACK_FIRST);
		run_frame(8'h88, 32'hFFFF_0000, 3'd4, NACK_SOME);
		run_frame(8'h3C, 32'h0000_FFFF, 3'd4, NACK_SOME);
		plain_beats(1);

		// Zero period runs as one
		set_period(16'd0);
		run_frame(8'h96, 32'h00C3_3C00, 3'd2, ACK_ALL);

		set_period(16'd2);
		run_frame(8'h81, 32'h7E7E_8181, 3'd4, ACK_ALL);

		// Longest period: a frame would outlast the run, so idle cycles only
		set_period(16'hFFFF);
		plain_beats(12);

		// Random frames over several periods, mostly short
		for (int ph = 0; ph < 5; ph++) begin
			no_gaps = (ph == 2 || ph == 3);
			if ($urandom_range(0, 3) == 0)
				ticks = PERIOD_W'($urandom_range(3, 5));
			else
				ticks = PERIOD_W'($urandom_range(1, 2));
			set_period(ticks);
			base = beats_sent;
			while (beats_sent - base < 50) begin
				plain_beats($urandom_range(0, 3));
				pick = $urandom_range(0, 99);
				if (pick < 70)
					plan = ACK_ALL;
				else if (pick < 85)
					plan = NACK_FIRST;
				else
					plan = NACK_SOME;
				run_frame(8'($urandom), 32'($urandom), 3'($urandom_range(0, 7)), plan);
			end
		end
		no_gaps = 1'b0;

		// Drain
		s_tvalid <= 1'b0;
		while (pending != 0)
			@(negedge clk);
		repeat (4) @(negedge clk);
		if (fail_count == 0)
			$display("two_wire_display_frame_sender verification clean");
		else
			$display("two_wire_display_frame_sender verification failed");
		$finish;
	end

endmodule
